// ===== rtl/ray_box_nearest_hit_unit_assert.svh =====
// Assertion macros for the ray/box nearest hit unit.
// Used by the controller and top level; no other dependencies.
`ifndef RAY_BOX_NEAREST_HIT_UNIT_ASSERT_SVH
`define RAY_BOX_NEAREST_HIT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RBH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RBH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RBH_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RBH_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/rbh_pkg.sv =====
// Shared types, constants and controller command codes for the ray/box unit.
// No dependencies.
package rbh_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_CFG = 6;
    localparam logic [31:0] QMAX = 32'h7fff_ffff;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 3'd2;
    localparam logic [OP_W-1:0] OP_DSTRT = 3'd3;
    localparam logic [OP_W-1:0] OP_DDONE = 3'd4;
    localparam logic [OP_W-1:0] OP_FIN   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [5:0]      stp;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic miss;
        logic last;
    } sts_t;
endpackage

// ===== rtl/ray_box_nearest_hit_unit.sv =====
// Ray versus oriented box nearest-hit unit, top level.
// Depends on rbh_pkg, rbh_controller, rbh_datapath, rbh_divider.
//
// Usage: program the ray through cfg_we/cfg_index/cfg_data (origin x,y,z at
// 0..2, direction x,y,z at 3..5) while idle. Stream boxes on the s_ channel;
// each transaction carries an affine matrix, local bounds, a tag and a last
// flag. Only the transaction flagged last produces one m_ transaction: hit
// flag, nearest tag, distance and world hit point.
// Sequence: a box is loaded, then runs 21 cofactor and det steps, nine
// inverse divisions, 27 dot product steps, six slab divisions (each division:
// issue, 50 restoring iterations at FRAC_BITS 16, completion) and 4
// test/update steps. A singular box skips from the det to the update step.
// A last box adds the hit point and result steps before m_valid rises.
// A new box is accepted only once the previous one is through.
// A stalled receiver holds m_valid and the payload; boxes keep flowing, and
// only the next last box waits in its result step until the pending result
// is taken. Reset clears the pick accumulator and sets the ray to the
// origin pointing along +z.
`include "ray_box_nearest_hit_unit_assert.svh"
module ray_box_nearest_hit_unit #(
    parameter int FRAC_BITS = rbh_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [63:0]        s_mat_a, s_mat_b, s_mat_c, s_mat_d, s_mat_e, s_mat_f,
    input  logic [63:0]        s_box_x, s_box_y, s_box_z, s_object_tag,
    input  logic               s_last_box,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [63:0]        m_nearest_tag,
    output logic [30:0]        m_distance,
    output logic signed [31:0] m_hit_x, m_hit_y, m_hit_z
);
    logic signed [31:0] ro_reg [3], rd_reg [3];
    rbh_pkg::cmd_t cmd;
    rbh_pkg::sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ro_reg[0] <= '0; ro_reg[1] <= '0; ro_reg[2] <= '0;
            rd_reg[0] <= '0; rd_reg[1] <= '0;
            rd_reg[2] <= 32'(1) <<< FRAC_BITS;
        end else if (cfg_we) begin
            if (cfg_index < 3'd3) ro_reg[cfg_index[1:0]] <= cfg_data;
            else if (cfg_index < 3'(rbh_pkg::NUM_CFG)) rd_reg[2'(cfg_index - 3'd3)] <= cfg_data;
        end
    end

    rbh_controller u_ctl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    rbh_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_mat_a(s_mat_a), .s_mat_b(s_mat_b), .s_mat_c(s_mat_c),
        .s_mat_d(s_mat_d), .s_mat_e(s_mat_e), .s_mat_f(s_mat_f),
        .s_box_x(s_box_x), .s_box_y(s_box_y), .s_box_z(s_box_z),
        .s_object_tag(s_object_tag), .s_last_box(s_last_box),
        .ro(ro_reg), .rd(rd_reg),
        .r_hit(m_hit), .r_tag(m_nearest_tag), .r_dist(m_distance),
        .r_px(m_hit_x), .r_py(m_hit_y), .r_pz(m_hit_z)
    );

    `RBH_ASSERT_NEXT(a_hold_dist, aclk, aresetn, m_valid && !m_ready, $stable(m_distance))
    `RBH_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_valid && !m_hit, m_distance == '0)
    `RBH_ASSERT_NEXT(a_hold_tag, aclk, aresetn, m_valid && !m_ready, $stable(m_nearest_tag))
endmodule

// ===== rtl/rbh_divider.sv =====
// Restoring divider: signed n (34b) * 2^FRAC / d (32b), truncating, saturated.
// Depends on rbh_pkg for nothing but is driven by rbh_datapath.
module rbh_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [33:0] num,
    input  logic signed [31:0] den,
    output logic               busy,
    output logic signed [31:0] quo
);
    localparam int NW = 34 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg;
    logic neg_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [33:0] an;
    logic [33:0] rs;
    logic [NW:0] sq;

    assign an = num[33] ? 34'(-num) : 34'(num);
    assign rs = {r_reg, q_reg[NW-1]};
    assign busy = (cnt_reg != '0);

    always_comb begin
        r_next = r_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        if (busy) begin
            if (rs >= {2'b00, d_reg}) begin
                r_next = 33'(rs - {2'b00, d_reg});
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = rs[32:0];
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(NW);
        end else begin
            cnt_reg <= cnt_next;
        end
        if (start) begin
            q_reg <= {an, {FRAC_BITS{1'b0}}};
            r_reg <= '0;
            d_reg <= den[31] ? 32'(-den) : 32'(den);
            neg_reg <= num[33] ^ den[31];
        end else begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    always_comb begin
        sq = neg_reg ? (NW+1)'(-{1'b0, q_reg}) : {1'b0, q_reg};
        if (!sq[NW] && sq[NW-1:31] != '0) quo = 32'h7fff_ffff;
        else if (sq[NW] && sq[NW-1:31] != '1) quo = 32'h8000_0000;
        else quo = sq[31:0];
    end
endmodule

// ===== rtl/rbh_datapath.sv =====
// Datapath: matrix inversion, ray transform, slab test and pick accumulator.
// Depends on rbh_pkg and rbh_divider; sequenced by rbh_controller.
module rbh_datapath #(
    parameter int FRAC_BITS = rbh_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rbh_pkg::cmd_t      cmd,
    output rbh_pkg::sts_t      sts,
    input  logic [63:0]        s_mat_a, s_mat_b, s_mat_c, s_mat_d, s_mat_e, s_mat_f,
    input  logic [63:0]        s_box_x, s_box_y, s_box_z, s_object_tag,
    input  logic               s_last_box,
    input  logic signed [31:0] ro [3],
    input  logic signed [31:0] rd [3],
    output logic               r_hit,
    output logic [63:0]        r_tag,
    output logic [30:0]        r_dist,
    output logic signed [31:0] r_px, r_py, r_pz
);
    logic signed [31:0] m_reg [12];
    logic signed [31:0] bmin_reg [3], bmax_reg [3];
    logic [63:0] tag_reg;
    logic last_reg;
    logic signed [31:0] a_reg [9], inv_reg [9];
    logic signed [31:0] det_reg, lo_reg [3], ld_reg [3], t1_reg, tmin_reg, tmax_reg;
    logic miss_reg;
    logic signed [31:0] bd_reg;
    logic any_reg;
    logic [63:0] bt_reg;
    logic r3min_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;

    logic signed [31:0] mx, my;
    logic signed [63:0] prod;
    logic signed [31:0] mq;
    logic signed [33:0] acc_reg;
    logic signed [31:0] accs;
    logic signed [33:0] dnum;
    logic signed [31:0] dden, dq;
    logic dbusy, dstart;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7fff_ffff) return 32'sh7fff_ffff;
        if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // shared multiplier: floor shift, saturated
    // cofactor 3 negated from the minimum is +2^31 in the det sum
    always_comb begin
        prod = (cmd.stp == 6'd19 && r3min_reg) ? (64'(mx) <<< 31) : mx * my;
        if (prod[63] == 1'b0 && prod[62:31+FRAC_BITS] != '0) mq = 32'sh7fff_ffff;
        else if (prod[63] && prod[62:31+FRAC_BITS] != '1) mq = 32'sh8000_0000;
        else mq = prod[31+FRAC_BITS:FRAC_BITS];
    end
    assign accs = sat34(acc_reg);

    // step map (cmd.stp): 0..17 cofactor products (2 per cofactor),
    // 18..20 det, 21..47 inverse t/o/d rows via serial dot products handled below
    logic [3:0] ci;
    logic [1:0] row;
    logic [1:0] ph;
    logic [1:0] col;
    logic [4:0] doff;
    logic [3:0] drem;
    logic [1:0] ax;
    always_comb begin
        mx = '0;
        my = '0;
        ci = '0;
        doff = 5'(cmd.stp - 6'd21);
        row = (doff >= 5'd18) ? 2'd2 : (doff >= 5'd9) ? 2'd1 : 2'd0;
        drem = 4'(doff - ((row == 2'd2) ? 5'd18 : (row == 2'd1) ? 5'd9 : 5'd0));
        ph = (drem >= 4'd6) ? 2'd2 : (drem >= 4'd3) ? 2'd1 : 2'd0;
        col = 2'(drem - ((ph == 2'd2) ? 4'd6 : (ph == 2'd1) ? 4'd3 : 4'd0));
        dnum = '0;
        dden = det_reg;
        dstart = 1'b0;
        if (cmd.stp < 6'd18) begin
            ci = 4'(cmd.stp >> 1);
            unique case (ci)
                4'd0: begin mx = cmd.stp[0] ? a_reg[5] : a_reg[4];
                    my = cmd.stp[0] ? a_reg[7] : a_reg[8]; end
                4'd1: begin mx = cmd.stp[0] ? a_reg[2] : a_reg[1];
                    my = cmd.stp[0] ? a_reg[7] : a_reg[8]; end
                4'd2: begin mx = cmd.stp[0] ? a_reg[2] : a_reg[1];
                    my = cmd.stp[0] ? a_reg[4] : a_reg[5]; end
                4'd3: begin mx = cmd.stp[0] ? a_reg[5] : a_reg[3];
                    my = cmd.stp[0] ? a_reg[6] : a_reg[8]; end
                4'd4: begin mx = cmd.stp[0] ? a_reg[2] : a_reg[0];
                    my = cmd.stp[0] ? a_reg[6] : a_reg[8]; end
                4'd5: begin mx = cmd.stp[0] ? a_reg[2] : a_reg[0];
                    my = cmd.stp[0] ? a_reg[3] : a_reg[5]; end
                4'd6: begin mx = cmd.stp[0] ? a_reg[4] : a_reg[3];
                    my = cmd.stp[0] ? a_reg[6] : a_reg[7]; end
                4'd7: begin mx = cmd.stp[0] ? a_reg[1] : a_reg[0];
                    my = cmd.stp[0] ? a_reg[6] : a_reg[7]; end
                4'd8: begin mx = cmd.stp[0] ? a_reg[1] : a_reg[0];
                    my = cmd.stp[0] ? a_reg[3] : a_reg[4]; end
                default: ;
            endcase
        end else if (cmd.stp < 6'd21) begin
            mx = a_reg[4'(cmd.stp - 6'd18)];
            my = inv_reg[4'(3 * (cmd.stp - 6'd18))];
        end else if (cmd.stp < 6'd48) begin
            // 27 products: 3 rows x (t, o, d) x 3 columns
            mx = inv_reg[4'(3 * row + col)];
            unique case (ph)
                2'd0: my = m_reg[4'(4 * col + 3)];
                2'd1: my = ro[col];
                default: my = rd[col];
            endcase
        end else if (cmd.stp == 6'd63) begin
            mx = rd[0];
            my = bd_reg;
        end else begin
            mx = rd[2'(cmd.stp - 6'd60)];
            my = bd_reg;
        end
        if (cmd.op == rbh_pkg::OP_DSTRT) begin
            dstart = 1'b1;
            if (cmd.stp < 6'd9) begin
                dnum = 34'(inv_reg[4'(cmd.stp)]);
            end else begin
                // slab: stp 9+2*axis(+1)
                dden = ld_reg[ax];
                dnum = cmd.stp[0]
                    ? 34'(bmin_reg[ax]) - 34'(lo_reg[ax])
                    : 34'(bmax_reg[ax]) - 34'(lo_reg[ax]);
            end
        end
    end

    rbh_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .num(dnum), .den(dden),
        .busy(dbusy), .quo(dq)
    );

    logic signed [31:0] it_reg;
    logic signed [31:0] t1n, t2n, nmin, nmax;
    always_comb begin
        ax = 2'((cmd.stp - 6'd9) >> 1);
        t1n = (t1_reg > dq) ? dq : t1_reg;
        t2n = (t1_reg > dq) ? t1_reg : dq;
        nmin = (t1n > tmin_reg) ? t1n : tmin_reg;
        nmax = (t2n < tmax_reg) ? t2n : tmax_reg;
    end

    assign sts.div_busy = dbusy;
    assign sts.miss = miss_reg;
    assign sts.last = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bd_reg <= 32'sh7fff_ffff;
            any_reg <= 1'b0;
            bt_reg <= '0;
            miss_reg <= 1'b0;
        end else begin
            unique case (cmd.op)
                rbh_pkg::OP_LOAD: begin
                    {m_reg[1], m_reg[0]} <= s_mat_a;
                    {m_reg[3], m_reg[2]} <= s_mat_b;
                    {m_reg[5], m_reg[4]} <= s_mat_c;
                    {m_reg[7], m_reg[6]} <= s_mat_d;
                    {m_reg[9], m_reg[8]} <= s_mat_e;
                    {m_reg[11], m_reg[10]} <= s_mat_f;
                    a_reg[0] <= s_mat_a[31:0]; a_reg[1] <= s_mat_a[63:32];
                    a_reg[2] <= s_mat_b[31:0]; a_reg[3] <= s_mat_c[31:0];
                    a_reg[4] <= s_mat_c[63:32]; a_reg[5] <= s_mat_d[31:0];
                    a_reg[6] <= s_mat_e[31:0]; a_reg[7] <= s_mat_e[63:32];
                    a_reg[8] <= s_mat_f[31:0];
                    bmin_reg[0] <= s_box_x[31:0]; bmax_reg[0] <= s_box_x[63:32];
                    bmin_reg[1] <= s_box_y[31:0]; bmax_reg[1] <= s_box_y[63:32];
                    bmin_reg[2] <= s_box_z[31:0]; bmax_reg[2] <= s_box_z[63:32];
                    tag_reg <= s_object_tag;
                    last_reg <= s_last_box;
                    miss_reg <= 1'b0;
                    acc_reg <= '0;
                    tmin_reg <= '0;
                    tmax_reg <= 32'sh7fff_ffff;
                end
                rbh_pkg::OP_STEP: begin
                    if (cmd.stp < 6'd18) begin
                        if (!cmd.stp[0]) begin
                            acc_reg <= 34'(mq);
                        end else begin
                            // odd-index cofactors carry a sign flip
                            inv_reg[ci] <= ci[0] ? sat34(-34'(sat34(acc_reg - 34'(mq))))
                                                 : sat34(acc_reg - 34'(mq));
                            if (ci == 4'd3)
                                r3min_reg <= (sat34(acc_reg - 34'(mq)) == 32'sh8000_0000);
                        end
                    end else if (cmd.stp < 6'd21) begin
                        if (cmd.stp == 6'd20) begin
                            det_reg <= sat34(acc_reg + 34'(mq));
                            miss_reg <= (sat34(acc_reg + 34'(mq)) == 0);
                            acc_reg <= '0;
                        end else begin
                            acc_reg <= (cmd.stp == 6'd18) ? 34'(mq) : acc_reg + 34'(mq);
                        end
                    end else if (cmd.stp < 6'd48) begin
                        if (col == 2'd0) acc_reg <= 34'(mq);
                        else if (col == 2'd1) acc_reg <= acc_reg + 34'(mq);
                        else begin
                            acc_reg <= '0;
                            unique case (ph)
                                2'd0: it_reg <= sat34(-34'(sat34(acc_reg + 34'(mq))));
                                2'd1: lo_reg[row] <= sat34(acc_reg + 34'(mq) + 34'(it_reg));
                                default: ld_reg[row] <= sat34(acc_reg + 34'(mq));
                            endcase
                        end
                    end else if (cmd.stp >= 6'd50 && cmd.stp < 6'd53) begin
                        // zero-direction axis: containment
                        if (ld_reg[2'(cmd.stp - 6'd50)] == 0 &&
                            (lo_reg[2'(cmd.stp - 6'd50)] < bmin_reg[2'(cmd.stp - 6'd50)] ||
                             lo_reg[2'(cmd.stp - 6'd50)] > bmax_reg[2'(cmd.stp - 6'd50)]))
                            miss_reg <= 1'b1;
                    end else if (cmd.stp == 6'd53) begin
                        if (!miss_reg && tmin_reg < bd_reg) begin
                            bd_reg <= tmin_reg;
                            any_reg <= 1'b1;
                            bt_reg <= tag_reg;
                        end
                    end else if (cmd.stp >= 6'd60) begin
                        unique case (cmd.stp)
                            6'd60: px_reg <= sat34(34'(ro[0]) + 34'(mq));
                            6'd61: py_reg <= sat34(34'(ro[1]) + 34'(mq));
                            default: pz_reg <= sat34(34'(ro[2]) + 34'(mq));
                        endcase
                    end
                end
                rbh_pkg::OP_DDONE: begin
                    if (cmd.stp < 6'd9) begin
                        inv_reg[4'(cmd.stp)] <= dq;
                    end else if (cmd.stp[0]) begin
                        t1_reg <= dq;
                    end else if (ld_reg[ax] != 0) begin
                        tmin_reg <= nmin;
                        tmax_reg <= nmax;
                        if (nmin > nmax) miss_reg <= 1'b1;
                    end
                end
                rbh_pkg::OP_FIN: begin
                    r_hit <= any_reg;
                    r_tag <= any_reg ? bt_reg : '0;
                    r_dist <= any_reg ? bd_reg[30:0] : '0;
                    r_px <= any_reg ? px_reg : '0;
                    r_py <= any_reg ? py_reg : '0;
                    r_pz <= any_reg ? pz_reg : '0;
                    bd_reg <= 32'sh7fff_ffff;
                    any_reg <= 1'b0;
                    bt_reg <= '0;
                end
                default: ;
            endcase
        end
    end
    logic unused_ax;
    assign unused_ax = ^{m_reg[9], m_reg[10], m_reg[8]};
endmodule

// ===== rtl/rbh_controller.sv =====
// Sequencer for one box transaction: inversion, transform, slab test, result.
// Depends on rbh_pkg; drives rbh_datapath through cmd_t/sts_t.
`include "ray_box_nearest_hit_unit_assert.svh"
module rbh_controller (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output rbh_pkg::cmd_t cmd,
    input  rbh_pkg::sts_t sts
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_DWT  = 3'd3;
    localparam logic [2:0] ST_PNT  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] stp_reg, stp_next;
    logic mv_reg, mv_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

    // step order: cof 0..17, det 18..20, div 0..8, dots 21..47,
    // slab div 9..14, containment 50..52, update 53, point 60..62, final
    always_comb begin
        state_next = state_reg;
        stp_next = stp_reg;
        mv_next = mv_reg;
        cmd.op = rbh_pkg::OP_NONE;
        cmd.stp = stp_reg;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.op = rbh_pkg::OP_LOAD;
                    state_next = ST_RUN;
                    stp_next = '0;
                end
            end
            ST_RUN: begin
                cmd.op = rbh_pkg::OP_STEP;
                if (stp_reg == 6'd20) begin
                    state_next = ST_DIV;
                    stp_next = '0;
                end else if (stp_reg == 6'd47) begin
                    state_next = ST_DIV;
                    stp_next = 6'd9;
                end else if (stp_reg == 6'd53) begin
                    state_next = sts.last ? ST_PNT : ST_IDLE;
                    stp_next = 6'd60;
                end else begin
                    stp_next = stp_reg + 6'd1;
                end
            end
            ST_DIV: begin
                // singular matrix: skip straight to the update step
                if (stp_reg == 6'd0 && sts.miss) begin
                    state_next = ST_RUN;
                    stp_next = 6'd53;
                end else begin
                    cmd.op = rbh_pkg::OP_DSTRT;
                    state_next = ST_DWT;
                end
            end
            ST_DWT: begin
                if (!sts.div_busy) begin
                    cmd.op = rbh_pkg::OP_DDONE;
                    if (stp_reg == 6'd8) begin
                        state_next = ST_RUN;
                        stp_next = 6'd21;
                    end else if (stp_reg == 6'd14) begin
                        state_next = ST_RUN;
                        stp_next = 6'd50;
                    end else begin
                        state_next = ST_DIV;
                        stp_next = stp_reg + 6'd1;
                    end
                end
            end
            ST_PNT: begin
                cmd.op = rbh_pkg::OP_STEP;
                if (stp_reg == 6'd62) state_next = ST_OUT;
                else stp_next = stp_reg + 6'd1;
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    cmd.op = rbh_pkg::OP_FIN;
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            stp_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            stp_reg <= stp_next;
            mv_reg <= mv_next;
        end
    end

    `RBH_ASSERT_NEXT(a_mv_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `RBH_ASSERT_IMPL(a_fin_free, aclk, aresetn, cmd.op == rbh_pkg::OP_FIN, !mv_reg)
    `RBH_ASSERT_NEXT(a_load_run, aclk, aresetn, s_valid && s_ready, state_reg == ST_RUN)
endmodule
